FILE: src/egcd_pkg.sv
// Package for the extended gcd / modular inverse block.
// Holds the shared operand width, the command and status structs and the controller states.
// No dependencies.
package egcd_pkg;

	localparam int unsigned OperandWidth = 32;

	// Controller states, one-hot.
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CHECK = 7'b0000010,
		ST_DIV   = 7'b0000100,
		ST_MUL   = 7'b0001000,
		ST_FIX   = 7'b0010000,
		ST_MOD   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture operands, set up the sequence
		logic div_start; // clear the divider for a new quotient
		logic div_step;  // one restoring division step
		logic mul_step;  // one shift-add step of q times s/t
		logic advance;   // shift the remainder and coefficient pairs
		logic fix_load;  // set up reduction of x modulo b
		logic mod_step;  // one step of the reduction
		logic finish;    // marks the last reduction step; unused by the datapath
	} egcd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic r_zero;   // current remainder is zero
		logic cnt_done; // bit counter is on its last step
	} egcd_sts_t;

endpackage

FILE: src/egcd_ctrl.sv
// Controller for the extended gcd block: sequences division, update and reduction.
// Depends on egcd_pkg.
module egcd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output egcd_pkg::egcd_cmd_t  cmd,
	input  egcd_pkg::egcd_sts_t  sts
);

	egcd_pkg::state_t state_q;
	logic             out_valid_q;

	assign in_ready  = state_q == egcd_pkg::ST_IDLE;
	assign out_valid = out_valid_q;

	// Command decode.
	always_comb begin
		cmd           = '0;
		cmd.load      = in_valid && in_ready;
		cmd.div_start = state_q == egcd_pkg::ST_CHECK && !sts.r_zero;
		cmd.div_step  = state_q == egcd_pkg::ST_DIV;
		cmd.mul_step  = state_q == egcd_pkg::ST_MUL;
		cmd.advance   = state_q == egcd_pkg::ST_MUL && sts.cnt_done;
		cmd.fix_load  = state_q == egcd_pkg::ST_FIX;
		cmd.mod_step  = state_q == egcd_pkg::ST_MOD;
		cmd.finish    = state_q == egcd_pkg::ST_MOD && sts.cnt_done;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= egcd_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				egcd_pkg::ST_IDLE: begin
					if (in_valid) state_q <= egcd_pkg::ST_CHECK;
				end
				egcd_pkg::ST_CHECK: begin
					state_q <= sts.r_zero ? egcd_pkg::ST_FIX : egcd_pkg::ST_DIV;
				end
				egcd_pkg::ST_DIV: begin
					if (sts.cnt_done) state_q <= egcd_pkg::ST_MUL;
				end
				egcd_pkg::ST_MUL: begin
					if (sts.cnt_done) state_q <= egcd_pkg::ST_CHECK;
				end
				egcd_pkg::ST_FIX: begin
					state_q <= egcd_pkg::ST_MOD;
				end
				egcd_pkg::ST_MOD: begin
					if (sts.cnt_done) begin
						state_q     <= egcd_pkg::ST_OUT;
						out_valid_q <= 1'b1;
					end
				end
				egcd_pkg::ST_OUT: begin
					if (out_ready) begin
						state_q     <= egcd_pkg::ST_IDLE;
						out_valid_q <= 1'b0;
					end
				end
				default: state_q <= egcd_pkg::ST_IDLE;
			endcase
		end
	end

	// The result is offered exactly in the output state.
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q == (state_q == egcd_pkg::ST_OUT))
		else $error("out_valid disagrees with state");
	// No input is taken while a result waits.
	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !in_ready)
		else $error("input accepted while busy");
	// The state register stays one-hot.
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state not one-hot");

endmodule

FILE: src/egcd_dp.sv
// Datapath for the extended gcd block: remainder pair, coefficient pairs,
// a bit-serial divider, a shift-add multiplier and a bit-serial reducer. Depends on egcd_pkg.
module egcd_dp #(
	parameter int unsigned OPERAND_WIDTH = egcd_pkg::OperandWidth
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  egcd_pkg::egcd_cmd_t        cmd,
	output egcd_pkg::egcd_sts_t        sts,
	input  logic [OPERAND_WIDTH-1:0]   value_a,
	input  logic [OPERAND_WIDTH-1:0]   value_b,
	output logic [OPERAND_WIDTH-1:0]   gcd_value,
	output logic signed [OPERAND_WIDTH:0] coef_x,
	output logic signed [OPERAND_WIDTH:0] coef_y,
	output logic [OPERAND_WIDTH-1:0]   inverse,
	output logic                       has_inverse
);

	localparam int unsigned W  = OPERAND_WIDTH;
	localparam int unsigned CW = OPERAND_WIDTH + 1;
	localparam int unsigned NW = $clog2(OPERAND_WIDTH + 1);

	logic [W-1:0]  r_prev_q, r_cur_q, b_q;
	logic [CW-1:0] s_prev_q, s_cur_q, t_prev_q, t_cur_q;
	logic [W-1:0]  quo_q, rem_q;   // dividend shifts out as the quotient shifts in, remainder builds
	logic [CW-1:0] qs_q, qt_q;     // products q*s_cur, q*t_cur
	logic [CW-1:0] ms_q, mt_q;     // multiplicands s_cur, t_cur held for the product
	logic [NW-1:0] cnt_q;
	logic          neg_q;
	logic [W-1:0]  mag_q;

	// Division step: shift in the next dividend bit and try to subtract.
	logic [W:0]   div_trial;
	logic [W-1:0] div_next;
	assign div_trial = {rem_q, quo_q[W-1]} - {1'b0, r_cur_q};
	assign div_next  = {rem_q[W-2:0], quo_q[W-1]};

	// Reduction step, same scheme with the modulus as divisor.
	logic [W:0] mod_trial;
	assign mod_trial = {rem_q, mag_q[W-1]} - {1'b0, b_q};

	assign sts.r_zero   = r_cur_q == '0;
	assign sts.cnt_done = cnt_q == NW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load || cmd.advance) begin
			cnt_q <= NW'(W);
		end else if (cmd.div_start || cmd.fix_load) begin
			cnt_q <= NW'(W);
		end else if ((cmd.div_step || cmd.mul_step || cmd.mod_step) && !sts.cnt_done) begin
			cnt_q <= cnt_q - NW'(1);
		end else if (cmd.div_step) begin
			cnt_q <= NW'(W);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r_prev_q <= value_a;
			r_cur_q  <= value_b;
			b_q      <= value_b;
			s_prev_q <= CW'(1);
			s_cur_q  <= '0;
			t_prev_q <= '0;
			t_cur_q  <= CW'(1);
		end
		if (cmd.div_start) begin
			quo_q <= r_prev_q;
			rem_q <= '0;
		end
		// Restoring division of r_prev by r_cur, one bit a cycle.
		if (cmd.div_step) begin
			if (!div_trial[W]) rem_q <= div_trial[W-1:0];
			else               rem_q <= div_next;
			quo_q <= {quo_q[W-2:0], ~div_trial[W]};
			if (sts.cnt_done) begin
				qs_q <= '0;
				qt_q <= '0;
				ms_q <= s_cur_q;
				mt_q <= t_cur_q;
			end
		end
		// Shift-add product of the quotient with s_cur and t_cur, MSB first.
		if (cmd.mul_step) begin
			qs_q <= {qs_q[CW-2:0], 1'b0} + (quo_q[W-1] ? ms_q : '0);
			qt_q <= {qt_q[CW-2:0], 1'b0} + (quo_q[W-1] ? mt_q : '0);
			quo_q <= {quo_q[W-2:0], 1'b0};
		end
		// Step the sequence with the final products.
		if (cmd.advance) begin
			r_prev_q <= r_cur_q;
			r_cur_q  <= rem_q;
			s_prev_q <= s_cur_q;
			s_cur_q  <= s_prev_q - ({qs_q[CW-2:0], 1'b0} + (quo_q[W-1] ? ms_q : '0));
			t_prev_q <= t_cur_q;
			t_cur_q  <= t_prev_q - ({qt_q[CW-2:0], 1'b0} + (quo_q[W-1] ? mt_q : '0));
		end
		// Reduce |x| modulo b.
		if (cmd.fix_load) begin
			neg_q <= s_prev_q[CW-1];
			mag_q <= s_prev_q[CW-1] ? W'(-s_prev_q) : s_prev_q[W-1:0];
			rem_q <= '0;
		end
		if (cmd.mod_step) begin
			if (!mod_trial[W]) rem_q <= mod_trial[W-1:0];
			else               rem_q <= {rem_q[W-2:0], mag_q[W-1]};
			mag_q <= {mag_q[W-2:0], 1'b0};
		end
	end

	// Result fields; the reduced remainder is final once the controller finishes.
	logic ok;
	assign ok          = r_prev_q == W'(1) && b_q != '0;
	assign gcd_value   = r_prev_q;
	assign coef_x      = s_prev_q;
	assign coef_y      = t_prev_q;
	assign has_inverse = ok;
	assign inverse     = !ok ? '0 : (neg_q && rem_q != '0) ? b_q - rem_q : rem_q;

endmodule

FILE: src/extended_gcd_modular_inverse.sv
// Channel  Direction  Handshake                  Payload
// in       input      in_valid / in_ready        value_a, value_b
// out      output     out_valid / out_ready      gcd_value, coef_x, coef_y, inverse, has_inverse
//
// One item at a time. Each Euclid iteration runs one check, W divider steps and W
// multiplier steps (W = OPERAND_WIDTH). The final check, the reduction setup and W
// reduction steps follow, and then the result is offered. The run time is set by the
// remainder loop, about 46 iterations for 32-bit operands in the worst case.
// Asynchronous reset returns the controller to idle; stalled results hold.
// Depends on egcd_pkg, egcd_ctrl and egcd_dp.
module extended_gcd_modular_inverse #(
	parameter int unsigned OPERAND_WIDTH = egcd_pkg::OperandWidth
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [OPERAND_WIDTH-1:0]     value_a,
	input  logic [OPERAND_WIDTH-1:0]     value_b,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [OPERAND_WIDTH-1:0]     gcd_value,
	output logic signed [OPERAND_WIDTH:0] coef_x,
	output logic signed [OPERAND_WIDTH:0] coef_y,
	output logic [OPERAND_WIDTH-1:0]     inverse,
	output logic                         has_inverse
);

	egcd_pkg::egcd_cmd_t cmd;
	egcd_pkg::egcd_sts_t sts;

	egcd_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
	);

	egcd_dp #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
		.clk, .arst_n, .cmd, .sts, .value_a, .value_b,
		.gcd_value, .coef_x, .coef_y, .inverse, .has_inverse
	);

endmodule

FILE: verif/tb.sv
// Self-checking testbench for extended_gcd_modular_inverse.
// Predicts gcd, Bezout coefficients and modular inverse for each operand pair.
// Depends on egcd_pkg and the block's RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = egcd_pkg::OperandWidth;
	localparam int RANDOM_ITEMS = 350;
	localparam longint CYCLE_LIMIT = 6000000;

	typedef struct {
		logic [W-1:0] gcd;
		logic [W:0]   x;
		logic [W:0]   y;
		logic [W-1:0] inv;
		logic         ok;
	} egcd_result_t;

	// Scoreboard of expected results, filled when an operand beat is accepted.
	class egcd_scoreboard;
		egcd_result_t pending[$];
		int errors;
		int checked;

		function egcd_result_t predict(logic [W-1:0] a, logic [W-1:0] b);
			egcd_result_t res;
			longint unsigned r0, r1, rn, q;
			longint s0, s1, t0, t1, sn, tn;
			longint unsigned mag, rem;
			r0 = a;
			r1 = b;
			s0 = 1;
			s1 = 0;
			t0 = 0;
			t1 = 1;
			while (r1 != 0) begin
				q = r0 / r1;
				rn = r0 - q * r1;
				sn = s0 - longint'(q) * s1;
				tn = t0 - longint'(q) * t1;
				r0 = r1;
				r1 = rn;
				s0 = s1;
				s1 = sn;
				t0 = t1;
				t1 = tn;
			end
			res.gcd = r0[W-1:0];
			res.x = s0[W:0];
			res.y = t0[W:0];
			res.inv = '0;
			res.ok = 1'b0;
			if (r0 == 1 && b != 0) begin
				mag = (s0 < 0) ? longint'(-s0) : longint'(s0);
				rem = mag % b;
				if (s0 < 0 && rem != 0)
					rem = b - rem;
				res.inv = rem[W-1:0];
				res.ok = 1'b1;
			end
			return res;
		endfunction

		function void note_operands(logic [W-1:0] a, logic [W-1:0] b);
			pending.push_back(predict(a, b));
		endfunction

		function void check_result(egcd_result_t got);
			egcd_result_t exp_r;
			checked++;
			if (pending.size() == 0) begin
				report_mismatch("result beat with nothing expected", 0, 0);
				return;
			end
			exp_r = pending.pop_front();
			if (got.gcd !== exp_r.gcd)
				report_mismatch("gcd_value", got.gcd, exp_r.gcd);
			if (got.x !== exp_r.x)
				report_mismatch("coef_x", got.x, exp_r.x);
			if (got.y !== exp_r.y)
				report_mismatch("coef_y", got.y, exp_r.y);
			if (got.inv !== exp_r.inv)
				report_mismatch("inverse", got.inv, exp_r.inv);
			if (got.ok !== exp_r.ok)
				report_mismatch("has_inverse", got.ok, exp_r.ok);
		endfunction

		function void report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			$display("mismatch on result %0d: %s got %h want %h", checked, what, got, want);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [W-1:0] value_a;
	logic [W-1:0] value_b;
	logic out_valid;
	logic out_ready;
	logic [W-1:0] gcd_value;
	logic signed [W:0] coef_x;
	logic signed [W:0] coef_y;
	logic [W-1:0] inverse;
	logic has_inverse;

	egcd_scoreboard sb = new();
	longint cycles = 0;
	int sent = 0;
	int stall_mode = 0;

	extended_gcd_modular_inverse dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.value_a(value_a), .value_b(value_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.gcd_value(gcd_value), .coef_x(coef_x), .coef_y(coef_y),
		.inverse(inverse), .has_inverse(has_inverse)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Cycle watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver: stalls follow a pattern that changes now and then.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				sb.check_result('{gcd_value, coef_x, coef_y, inverse, has_inverse});
			if ($urandom_range(0, 199) == 0)
				stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) == 0);
				2: out_ready <= ($urandom_range(0, 9) == 0);
				default: out_ready <= (cycles[4:0] > 5'd7);
			endcase
		end
	end

	// Presents one operand beat and holds it until accepted.
	task automatic send_pair(logic [W-1:0] a, logic [W-1:0] b);
		value_a <= a;
		value_b <= b;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_operands(a, b);
		sent++;
	endtask

	task automatic idle_cycles(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Waits until every expected result has come back.
	task automatic drain();
		idle_cycles(1);
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [W-1:0] rand_word();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 15);
			1: return $urandom_range(0, 65535);
			2: return {$urandom} | 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int burst;
		logic [W-1:0] a, b, p;
		logic [W-1:0] ones;
		ones = '1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		value_a = '0;
		value_b = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs: zeros, modulus one, extremes, consecutive Fibonacci numbers.
		send_pair(0, 0);
		send_pair(5, 0);
		send_pair(1, 0);
		send_pair(0, 7);
		send_pair(9, 1);
		send_pair(0, 1);
		send_pair(1, 1);
		send_pair(ones, ones);
		send_pair(ones, 1);
		send_pair(ones, ones - 1);
		send_pair(ones - 1, ones);
		send_pair(3, 7);
		send_pair(6, 9);
		send_pair(7, 3);
		send_pair(32'd2971215073, 32'd1836311903);
		send_pair(32'd1836311903, 32'd2971215073);
		send_pair(32'h8000_0000, 32'h7FFF_FFFF);
		send_pair(32'h5555_5555, 32'hAAAA_AAAA);
		send_pair(ones, 32'h8000_0000);
		send_pair(12, 18);
		// Hold off until the block has drained completely.
		drain();

		// Random bursts with gaps; a mix of coprime and common-factor pairs.
		while (sent < 20 + RANDOM_ITEMS) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				a = rand_word();
				b = rand_word();
				if ($urandom_range(0, 4) == 0) begin
					p = $urandom_range(2, 1000);
					a = (a % (ones / p)) * p;
					b = (b % (ones / p)) * p;
				end
				if ($urandom_range(0, 29) == 0)
					b = 0;
				send_pair(a, b);
			end
			if ($urandom_range(0, 2) != 0)
				idle_cycles($urandom_range(1, 3000));
		end

		drain();
		repeat (2000) @(posedge clk);
		$display("Checked %0d results from %0d operand pairs, directed and random.",
			sb.checked, sent);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

FILE: files.f
src/egcd_pkg.sv
src/egcd_ctrl.sv
src/egcd_dp.sv
src/extended_gcd_modular_inverse.sv
verif/tb.sv
